// ===== rtl/sla_pkg.sv =====
// Package: payload types, opcode codes and state entry layout for the SIMD lane ALU.
package sla_pkg;

  localparam int LANES_DEF = 1024;
  localparam int LANE_W    = 10;
  localparam int DATA_W    = 16;

  localparam logic [3:0] CMD_ADD    = 4'd0;
  localparam logic [3:0] CMD_SUB    = 4'd1;
  localparam logic [3:0] CMD_EQ     = 4'd2;
  localparam logic [3:0] CMD_LT     = 4'd3;
  localparam logic [3:0] CMD_OR     = 4'd4;
  localparam logic [3:0] CMD_AND    = 4'd5;
  localparam logic [3:0] CMD_XOR    = 4'd6;
  localparam logic [3:0] CMD_MUL    = 4'd7;
  localparam logic [3:0] CMD_MULU   = 4'd8;
  localparam logic [3:0] CMD_NOT    = 4'd9;
  localparam logic [3:0] CMD_BITREV = 4'd10;
  localparam logic [3:0] CMD_ULT    = 4'd11;
  localparam logic [3:0] CMD_SHL    = 4'd12;
  localparam logic [3:0] CMD_SHR    = 4'd13;
  localparam logic [3:0] CMD_SHRA   = 4'd14;
  localparam logic [3:0] CMD_POPCNT = 4'd15;

  typedef struct packed {
    logic [3:0]               cmd;
    logic [LANE_W-1:0]        lane;
    logic signed [DATA_W-1:0] operand_a;
    logic signed [DATA_W-1:0] operand_b;
    logic                     lane_enabled;
  } sla_in_t;

  typedef struct packed {
    logic [DATA_W-1:0] result_value;
    logic              write_enable;
    logic              eq_out;
    logic              lt_out;
    logic              carry_out;
    logic [DATA_W-1:0] product_low;
    logic [DATA_W-1:0] product_high;
  } sla_out_t;

  typedef struct packed {
    logic              eq;
    logic              lt;
    logic              carry;
    logic [DATA_W-1:0] prod_hi;
    logic [DATA_W-1:0] prod_lo;
  } sla_entry_t;

endpackage

// ===== rtl/simd_lane_alu_with_flags_core.sv =====
// Top level: per-lane 16-bit ALU with flag and product state held in one RAM.
// A transaction passes the quotient, index, execute and output states; the output
// state waits on out_ready. The RAM read-modify-write sequence (index reduction,
// read, execute and write, output load) handles one lane and one transaction at a time.
// Reset: after rst_n the RAM is cleared over LANES cycles, one entry per cycle,
// with in_ready low; the output register comes up empty.
module simd_lane_alu_with_flags_core #(
  parameter int LANES = sla_pkg::LANES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sla_pkg::sla_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output sla_pkg::sla_out_t out_data
);

  import sla_pkg::*;

  localparam int AW      = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int RSH     = 20;
  localparam int RECIP   = (1 << RSH) / LANES;
  localparam int ENT_W   = $bits(sla_entry_t);
  localparam int PRODQ_W = LANE_W + RSH + 1;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_QUOT  = 3'd2;
  localparam logic [2:0] ST_INDEX = 3'd3;
  localparam logic [2:0] ST_EXEC  = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [AW-1:0]     clr_cnt_r, clr_cnt_nxt;
  sla_in_t           in_r;
  logic [LANE_W-1:0] quot_r;
  logic [AW-1:0]     idx_r;
  sla_out_t          res_r;
  sla_out_t          out_r;
  logic              out_valid_r, out_valid_nxt;

  logic [PRODQ_W-1:0] quot_full;
  logic [23:0]        rem_raw, rem_fix;
  logic [AW-1:0]      idx_w;

  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr;
  logic [ENT_W-1:0] ram_wdata, ram_rdata;

  sla_entry_t         ent_rd, ent_new;
  logic [DATA_W-1:0]  ua, ub, res_val, rev_w;
  logic [4:0]         sh;
  logic [DATA_W:0]    sum_ab, sum_abc, ub_c;
  logic               eq_w, slt_w, ult_w, cy_w, c_in;
  logic signed [16:0] ma, mb;
  logic signed [33:0] prod_w;
  logic               out_load;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_load  = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  // lane modulo LANES by reciprocal, one correction step
  assign quot_full = PRODQ_W'(in_r.lane) * PRODQ_W'(RECIP);
  assign rem_raw   = 24'(in_r.lane) - 24'(quot_r) * 24'(LANES);
  assign rem_fix   = (rem_raw >= 24'(LANES)) ? rem_raw - 24'(LANES) : rem_raw;
  assign idx_w     = rem_fix[AW-1:0];

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = ENT_W'(ent_new);
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = '0;
    end else if (state_r == ST_EXEC) begin
      ram_we = 1'b1;
    end
  end

  assign ram_re = (state_r == ST_INDEX);

  sla_ram #(
    .WIDTH (ENT_W),
    .DEPTH (LANES),
    .AW    (AW)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (idx_w),
    .rdata (ram_rdata)
  );

  // execute
  assign ent_rd  = sla_entry_t'(ram_rdata);
  assign c_in    = ent_rd.carry;
  assign ua      = in_r.operand_a;
  assign ub      = in_r.operand_b;
  assign sh      = ub[4:0];
  assign eq_w    = (ua == ub);
  assign slt_w   = ($signed(ua) < $signed(ub));
  assign ult_w   = (ua < ub);
  assign sum_ab  = {1'b0, ua} + {1'b0, ub};
  assign sum_abc = sum_ab + {16'd0, c_in};
  assign ub_c    = {1'b0, ub} + {16'd0, c_in};
  assign ma      = {(in_r.cmd == CMD_MUL) & ua[15], ua};
  assign mb      = {(in_r.cmd == CMD_MUL) & ub[15], ub};
  assign prod_w  = ma * mb;

  always_comb begin
    for (int k = 0; k < DATA_W; k++) begin
      rev_w[DATA_W-1-k] = ua[k];
    end
  end

  always_comb begin
    case (in_r.cmd)
      CMD_ADD, CMD_EQ:         cy_w = sum_ab[DATA_W];
      CMD_SUB, CMD_LT, CMD_OR: cy_w = ult_w;
      CMD_AND:                 cy_w = sum_abc[DATA_W];
      CMD_XOR:                 cy_w = ({1'b0, ua} < ub_c);
      default:                 cy_w = c_in;
    endcase
  end

  always_comb begin
    ent_new = ent_rd;
    res_val = '0;
    case (in_r.cmd)
      CMD_ADD: res_val = sum_ab[DATA_W-1:0];
      CMD_SUB: res_val = ua - ub;
      CMD_EQ:  res_val = {15'd0, eq_w};
      CMD_LT:  res_val = {15'd0, slt_w};
      CMD_OR:  res_val = ua | ub;
      CMD_AND: res_val = ua & ub;
      CMD_XOR: res_val = ua ^ ub;
      CMD_MUL, CMD_MULU: begin
        if (in_r.lane_enabled) begin
          ent_new.prod_lo = prod_w[15:0];
          ent_new.prod_hi = prod_w[31:16];
        end
      end
      CMD_NOT:    res_val = ~ua;
      CMD_BITREV: res_val = rev_w;
      CMD_ULT:    res_val = {15'd0, ult_w};
      CMD_SHL:    res_val = ua << sh;
      CMD_SHR:    res_val = ua >> sh;
      CMD_SHRA:   res_val = DATA_W'($signed(ua) >>> sh);
      CMD_POPCNT: res_val = DATA_W'($countones(ua));
      default:    res_val = '0;
    endcase
    if (in_r.cmd inside {[CMD_ADD:CMD_XOR]}) begin
      ent_new.eq    = eq_w;
      ent_new.lt    = slt_w;
      ent_new.carry = cy_w;
    end else if (!in_r.lane_enabled) begin
      res_val = '0;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == AW'(LANES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_QUOT;
        end
      end
      ST_QUOT:  state_nxt = ST_INDEX;
      ST_INDEX: state_nxt = ST_EXEC;
      ST_EXEC:  state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (state_r == ST_QUOT) begin
      quot_r <= quot_full[RSH +: LANE_W];
    end
    if (state_r == ST_INDEX) begin
      idx_r <= idx_w;
    end
    if (state_r == ST_EXEC) begin
      res_r.result_value <= res_val;
      res_r.write_enable <= in_r.lane_enabled;
      res_r.eq_out       <= ent_new.eq;
      res_r.lt_out       <= ent_new.lt;
      res_r.carry_out    <= ent_new.carry;
      res_r.product_low  <= ent_new.prod_lo;
      res_r.product_high <= ent_new.prod_hi;
    end
    if (out_load) begin
      out_r <= res_r;
    end
  end

endmodule

// ===== rtl/sla_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== dv/simd_lane_alu_with_flags_core_tb.sv =====
`timescale 1ns / 100ps
// SIMD lane ALU testbench: directed table plus random traffic, checked by table or lane-state predictor.
module simd_lane_alu_with_flags_core_tb;
  import sla_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_TXNS    = 1200;
  localparam int HOLD_CYCLES    = 300;

  typedef struct packed {
    sla_in_t  item;
    logic     known;
    sla_out_t want;
  } dir_row_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  sla_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  sla_out_t out_data;

  logic              lane_eq  [LANES_DEF];
  logic              lane_lt  [LANES_DEF];
  logic              lane_cy  [LANES_DEF];
  logic [DATA_W-1:0] lane_plo [LANES_DEF];
  logic [DATA_W-1:0] lane_phi [LANES_DEF];

  sla_out_t expected_results[$];
  dir_row_t dir_rows[$];
  int       err_cnt = 0;
  int       sent_cnt = 0;
  int       rx_cnt = 0;
  int       rx_gap = 0;
  int       idle_cycles = 0;
  bit       tx_burst = 1'b0;
  logic     rx_hold = 1'b0;

  simd_lane_alu_with_flags_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic sla_out_t alu_predict(sla_in_t t);
    sla_out_t          r;
    int unsigned       idx;
    logic [DATA_W-1:0] ua, ub, rv;
    logic [DATA_W:0]   sum;
    logic [4:0]        sh;
    logic              cin, cy;
    int                sa, sb;
    logic [31:0]       prod;
    int                k;
    idx  = t.lane % LANES_DEF;
    ua   = t.operand_a;
    ub   = t.operand_b;
    sa   = $signed(t.operand_a);
    sb   = $signed(t.operand_b);
    sh   = ub[4:0];
    cin  = lane_cy[idx];
    rv   = '0;
    cy   = 1'b0;
    if (t.cmd <= CMD_XOR) begin
      case (t.cmd)
        CMD_ADD: begin
          rv  = ua + ub;
          sum = {1'b0, ua} + {1'b0, ub};
          cy  = sum[DATA_W];
        end
        CMD_SUB: begin
          rv = ua - ub;
          cy = ua < ub;
        end
        CMD_EQ: begin
          rv  = (ua == ub) ? 16'd1 : 16'd0;
          sum = {1'b0, ua} + {1'b0, ub};
          cy  = sum[DATA_W];
        end
        CMD_LT: begin
          rv = (sa < sb) ? 16'd1 : 16'd0;
          cy = ua < ub;
        end
        CMD_OR: begin
          rv = ua | ub;
          cy = ua < ub;
        end
        CMD_AND: begin
          rv  = ua & ub;
          sum = {1'b0, ua} + {1'b0, ub} + {16'd0, cin};
          cy  = sum[DATA_W];
        end
        default: begin
          rv = ua ^ ub;
          cy = {1'b0, ua} < ({1'b0, ub} + {16'd0, cin});
        end
      endcase
      lane_eq[idx] = (ua == ub);
      lane_lt[idx] = (sa < sb);
      lane_cy[idx] = cy;
    end else if (t.cmd == CMD_MUL || t.cmd == CMD_MULU) begin
      if (t.lane_enabled) begin
        if (t.cmd == CMD_MUL) prod = sa * sb;
        else prod = {16'd0, ua} * {16'd0, ub};
        lane_plo[idx] = prod[15:0];
        lane_phi[idx] = prod[31:16];
      end
    end else if (t.lane_enabled) begin
      case (t.cmd)
        CMD_NOT:    rv = ~ua;
        CMD_BITREV: for (k = 0; k < DATA_W; k++) rv[DATA_W-1-k] = ua[k];
        CMD_ULT:    rv = (ua < ub) ? 16'd1 : 16'd0;
        CMD_SHL:    rv = ua << sh;
        CMD_SHR:    rv = ua >> sh;
        CMD_SHRA:   rv = $signed(ua) >>> sh;
        default:    rv = DATA_W'($countones(ua));
      endcase
    end
    r.result_value = rv;
    r.write_enable = t.lane_enabled;
    r.eq_out       = lane_eq[idx];
    r.lt_out       = lane_lt[idx];
    r.carry_out    = lane_cy[idx];
    r.product_low  = lane_plo[idx];
    r.product_high = lane_phi[idx];
    return r;
  endfunction

  function automatic sla_in_t mk_in(logic [3:0] cmd, logic [LANE_W-1:0] lane,
                                    logic [DATA_W-1:0] a, logic [DATA_W-1:0] b, logic en);
    sla_in_t t;
    t.cmd          = cmd;
    t.lane         = lane;
    t.operand_a    = a;
    t.operand_b    = b;
    t.lane_enabled = en;
    return t;
  endfunction

  function automatic dir_row_t drow(sla_in_t item, logic known, sla_out_t want);
    dir_row_t d;
    d.item  = item;
    d.known = known;
    d.want  = want;
    return d;
  endfunction

  function automatic logic [DATA_W-1:0] draw_operand();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h7FFF;
      3:       return 16'h8000;
      4:       return 16'h0001;
      default: return DATA_W'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  function automatic sla_in_t draw_alu_txn();
    sla_in_t t;
    t.cmd          = 4'($urandom_range(0, 15));
    t.lane         = ($urandom_range(0, 3) == 0) ? LANE_W'($urandom_range(0, LANES_DEF - 1))
                                                 : LANE_W'($urandom_range(0, 7));
    t.operand_a    = draw_operand();
    t.operand_b    = ($urandom_range(0, 5) == 0) ? t.operand_a : draw_operand();
    t.lane_enabled = ($urandom_range(0, 3) != 0);
    return t;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    err_cnt++;
    if (err_cnt <= 50) $display("mismatch %0s: got %h want %h", what, got, want);
  endtask

  task automatic send_txn(sla_in_t item, logic known, sla_out_t want);
    int       gap;
    sla_out_t pred;
    gap = tx_burst ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    pred = alu_predict(item);
    expected_results.push_back(known ? want : pred);
    sent_cnt++;
  endtask

  // result side: random stalls per transaction, plus checking
  always @(posedge clk) begin : rx_side
    sla_out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        rx_cnt++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected transaction", 32'(out_data.result_value), 32'd0);
        end else begin
          want = expected_results.pop_front();
          if (out_data.result_value !== want.result_value)
            report_mismatch("result_value", 32'(out_data.result_value),
                            32'(want.result_value));
          if (out_data.write_enable !== want.write_enable)
            report_mismatch("write_enable", 32'(out_data.write_enable),
                            32'(want.write_enable));
          if (out_data.eq_out !== want.eq_out)
            report_mismatch("eq_out", 32'(out_data.eq_out), 32'(want.eq_out));
          if (out_data.lt_out !== want.lt_out)
            report_mismatch("lt_out", 32'(out_data.lt_out), 32'(want.lt_out));
          if (out_data.carry_out !== want.carry_out)
            report_mismatch("carry_out", 32'(out_data.carry_out), 32'(want.carry_out));
          if (out_data.product_low !== want.product_low)
            report_mismatch("product_low", 32'(out_data.product_low),
                            32'(want.product_low));
          if (out_data.product_high !== want.product_high)
            report_mismatch("product_high", 32'(out_data.product_high),
                            32'(want.product_high));
        end
        rx_gap = (((rx_cnt / 120) % 3) == 2) ? 0 : $urandom_range(0, 14);
      end
      if (rx_gap > 0) begin
        rx_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !rx_hold;
      end
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin : rx_holdoff
    wait (sent_cnt >= 400);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stim
    int i;
    // lane state comes out of reset all zero
    foreach (lane_eq[j]) begin
      lane_eq[j]  = 1'b0;
      lane_lt[j]  = 1'b0;
      lane_cy[j]  = 1'b0;
      lane_plo[j] = '0;
      lane_phi[j] = '0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // fresh lanes: flags and products read as zero before the item
    dir_rows.push_back(drow(mk_in(CMD_ADD, 10'd0, 16'h0000, 16'h0000, 1'b1), 1'b1,
                            {16'h0000, 1'b1, 1'b1, 1'b0, 1'b0, 16'h0000, 16'h0000}));
    dir_rows.push_back(drow(mk_in(CMD_ADD, 10'd1, 16'hFFFF, 16'h0001, 1'b1), 1'b1,
                            {16'h0000, 1'b1, 1'b0, 1'b1, 1'b1, 16'h0000, 16'h0000}));
    dir_rows.push_back(drow(mk_in(CMD_SUB, 10'd2, 16'h8000, 16'h7FFF, 1'b1), 1'b1,
                            {16'h0001, 1'b1, 1'b0, 1'b1, 1'b0, 16'h0000, 16'h0000}));
    dir_rows.push_back(drow(mk_in(CMD_MUL, 10'd3, 16'h8000, 16'h8000, 1'b1), 1'b1,
                            {16'h0000, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h4000}));
    dir_rows.push_back(drow(mk_in(CMD_MULU, 10'd4, 16'hFFFF, 16'hFFFF, 1'b1), 1'b1,
                            {16'h0000, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0001, 16'hFFFE}));
    dir_rows.push_back(drow(mk_in(CMD_MUL, 10'd5, 16'h7FFF, 16'h7FFF, 1'b0), 1'b1,
                            {16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000}));
    dir_rows.push_back(drow(mk_in(CMD_NOT, 10'd6, 16'h1234, 16'h0000, 1'b0), 1'b1,
                            {16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000}));
    dir_rows.push_back(drow(mk_in(CMD_SHL, 10'd7, 16'hFFFF, 16'h0010, 1'b1), 1'b1,
                            {16'h0000, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000}));
    dir_rows.push_back(drow(mk_in(CMD_SHRA, 10'd8, 16'h8000, 16'h001F, 1'b1), 1'b1,
                            {16'hFFFF, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000}));
    dir_rows.push_back(drow(mk_in(CMD_SHRA, 10'd9, 16'h7FFF, 16'hFFF0, 1'b1), 1'b1,
                            {16'h0000, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000}));
    dir_rows.push_back(drow(mk_in(CMD_SHR, 10'd10, 16'hFFFF, 16'h0013, 1'b1), 1'b1,
                            {16'h0000, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000}));
    dir_rows.push_back(drow(mk_in(CMD_POPCNT, 10'd11, 16'hFFFF, 16'h0000, 1'b1), 1'b1,
                            {16'h0010, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000}));
    dir_rows.push_back(drow(mk_in(CMD_BITREV, 10'd12, 16'h0001, 16'h0000, 1'b1), 1'b1,
                            {16'h8000, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000}));
    dir_rows.push_back(drow(mk_in(CMD_ULT, 10'd13, 16'h0000, 16'hFFFF, 1'b1), 1'b1,
                            {16'h0001, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000}));
    dir_rows.push_back(drow(mk_in(CMD_EQ, 10'd14, 16'h1234, 16'h1234, 1'b0), 1'b1,
                            {16'h0001, 1'b0, 1'b1, 1'b0, 1'b0, 16'h0000, 16'h0000}));
    dir_rows.push_back(drow(mk_in(CMD_LT, 10'd15, 16'hFFFF, 16'h0000, 1'b1), 1'b0, '0));
    dir_rows.push_back(drow(mk_in(CMD_OR, 10'd16, 16'hA5A5, 16'h5A5A, 1'b1), 1'b0, '0));
    // carry-in chains for and / xor, then a shift and three items on top lane 1023
    dir_rows.push_back(drow(mk_in(CMD_ADD, 10'd17, 16'hFFFF, 16'hFFFF, 1'b1), 1'b0, '0));
    dir_rows.push_back(drow(mk_in(CMD_AND, 10'd17, 16'hFFFF, 16'h0000, 1'b1), 1'b0, '0));
    dir_rows.push_back(drow(mk_in(CMD_SUB, 10'd18, 16'h0000, 16'h0001, 1'b1), 1'b0, '0));
    dir_rows.push_back(drow(mk_in(CMD_XOR, 10'd18, 16'h0001, 16'h0000, 1'b1), 1'b0, '0));
    dir_rows.push_back(drow(mk_in(CMD_SHL, 10'd19, 16'h0001, 16'h000F, 1'b1), 1'b0, '0));
    dir_rows.push_back(drow(mk_in(CMD_NOT, 10'd1023, 16'h0000, 16'h0000, 1'b1), 1'b0, '0));
    dir_rows.push_back(drow(mk_in(CMD_MUL, 10'd1023, 16'h7FFF, 16'h8000, 1'b1), 1'b0, '0));
    dir_rows.push_back(drow(mk_in(CMD_ADD, 10'd1023, 16'h7FFF, 16'h7FFF, 1'b0), 1'b0, '0));

    foreach (dir_rows[i]) send_txn(dir_rows[i].item, dir_rows[i].known, dir_rows[i].want);

    for (i = 0; i < RANDOM_TXNS; i++) begin
      tx_burst = (((i / 150) % 3) == 1);
      if (i == 600) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
      end
      send_txn(draw_alu_txn(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
